### design/per_column_top_k_neighbor_tracker_defines.svh
`ifndef PER_COLUMN_TOP_K_NEIGHBOR_TRACKER_DEFINES_SVH
`define PER_COLUMN_TOP_K_NEIGHBOR_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pctk_pkg.sv
`timescale 1ns / 1ps
package pctk_pkg;

  localparam int unsigned DEF_MAX_SLOTS   = 8;
  localparam int unsigned DEF_MAX_COLUMNS = 16;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned SIM_W   = 32;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned RCOL_W  = 4;
  localparam int unsigned RSLOT_W = 3;

  localparam int unsigned ID_LSB    = 0;
  localparam int unsigned SIM_LSB   = ID_LSB + ID_W;
  localparam int unsigned MASK_LSB  = SIM_LSB + SIM_W;
  localparam int unsigned RCOL_LSB  = MASK_LSB + MASK_W;
  localparam int unsigned RSLOT_LSB = RCOL_LSB + RCOL_W;
  localparam int unsigned IN_DATA_W = 72;

  localparam int unsigned RES_W      = 1 + MASK_W + ID_W + SIM_W;
  localparam int unsigned OUT_DATA_W = 72;

  localparam int unsigned KREG_W     = 4;
  localparam int unsigned CREG_W     = 5;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBORS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 1'b1;

  localparam logic [KREG_W-1:0] K_RESET = 4'd8;
  localparam logic [CREG_W-1:0] C_RESET = 5'd16;

  localparam logic [SIM_W-1:0] SIM_EMPTY = 32'h8000_0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef struct packed {
    logic clear;    // empty all slots, reset min index
    logic use_min;  // address the RAM with the lane's own min slot
    logic look;     // compare candidate against the fetched min slot
    logic dv;       // rescan data returns this cycle
    logic last;     // returning data is the last slot of the rescan
  } lane_ctl_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] slot_sim;
    logic [ID_W-1:0]         slot_id;
    logic [MASK_W-1:0]       updated_mask;
    logic                    accepted;
  } res_t;

endpackage

### design/pctk_ram.sv
`timescale 1ns / 1ps
module pctk_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/pctk_lane.sv
`timescale 1ns / 1ps
`include "per_column_top_k_neighbor_tracker_defines.svh"
module pctk_lane #(
  parameter int unsigned MAX_SLOTS = pctk_pkg::DEF_MAX_SLOTS,
  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
  localparam int unsigned KW = $clog2(MAX_SLOTS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pctk_pkg::lane_ctl_t            ctl_i,
  input  logic                           en_i,
  input  logic [KW-1:0]                  k_i,
  input  logic [SW-1:0]                  addr_i,
  input  logic [pctk_pkg::ID_W-1:0]      cand_id_i,
  input  logic signed [pctk_pkg::SIM_W-1:0] cand_sim_i,
  output logic                           take_o,
  output logic [pctk_pkg::ID_W-1:0]      rd_id_o,
  output logic signed [pctk_pkg::SIM_W-1:0] rd_sim_o
);

  import pctk_pkg::*;

  logic [SW-1:0]              min_idx_q;
  logic [MAX_SLOTS-1:0]       vld_q;
  logic                       take_q;
  logic [SW-1:0]              min_eff;
  logic [SW-1:0]              raddr;
  logic [SW-1:0]              rd_addr_q;
  logic [ID_W+SIM_W-1:0]      wdata;
  logic [ID_W+SIM_W-1:0]      rdata;
  logic signed [SIM_W-1:0]    ram_sim;
  logic signed [SIM_W-1:0]    slot_sim;
  logic signed [SIM_W-1:0]    run_sim_q;
  logic [SW-1:0]              run_idx_q;
  logic                       first;
  logic                       better;
  logic [SW-1:0]              next_idx;

  // A min index left beyond K by a lowered K falls back to slot 0.
  assign min_eff = (KW'(min_idx_q) >= k_i) ? '0 : min_idx_q;
  assign raddr   = ctl_i.use_min ? min_eff : addr_i;
  assign wdata   = {cand_id_i, cand_sim_i};

  pctk_ram #(
    .WIDTH(ID_W + SIM_W),
    .DEPTH(MAX_SLOTS)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (take_o),
    .waddr_i(rd_addr_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign ram_sim  = rdata[SIM_W-1:0];
  assign slot_sim = vld_q[rd_addr_q] ? ram_sim : SIM_EMPTY;
  assign rd_sim_o = slot_sim;
  assign rd_id_o  = rdata[ID_W+SIM_W-1:SIM_W];

  assign take_o = ctl_i.look && en_i && (cand_sim_i > slot_sim);

  // Rescan: earliest slot wins ties, so replace only on a strictly lower value.
  assign first    = (rd_addr_q == '0);
  assign better   = run_sim_q > slot_sim;
  assign next_idx = (first || better) ? rd_addr_q : run_idx_q;

  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr;
    if (ctl_i.dv) begin
      run_sim_q <= (first || better) ? slot_sim : run_sim_q;
      run_idx_q <= next_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_idx_q <= '0;
      vld_q     <= '0;
      take_q    <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        vld_q     <= '0;
        min_idx_q <= '0;
      end
      if (ctl_i.look) begin
        take_q <= take_o;
        if (take_o) begin
          vld_q[rd_addr_q] <= 1'b1;
        end
      end
      if (ctl_i.dv && ctl_i.last && take_q) begin
        min_idx_q <= next_idx;
      end
    end
  end

  `PCTK_ASSERT_NEXT(a_min_in_range, ctl_i.dv && ctl_i.last && take_q, KW'(min_idx_q) < k_i, "min slot index beyond K after rescan")

endmodule

### design/pctk_merge.sv
`timescale 1ns / 1ps
module pctk_merge #(
  parameter int unsigned MAX_SLOTS   = pctk_pkg::DEF_MAX_SLOTS,
  parameter int unsigned MAX_COLUMNS = pctk_pkg::DEF_MAX_COLUMNS,
  localparam int unsigned KW  = $clog2(MAX_SLOTS + 1),
  localparam int unsigned CLW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  logic [pctk_pkg::REQ_W-1:0]        req_i,
  input  logic [MAX_COLUMNS-1:0]            take_i,
  input  logic [pctk_pkg::ID_W-1:0]         lane_id_i [MAX_COLUMNS],
  input  logic signed [pctk_pkg::SIM_W-1:0] lane_sim_i [MAX_COLUMNS],
  input  logic [pctk_pkg::RCOL_W-1:0]       rd_col_i,
  input  logic [pctk_pkg::RSLOT_W-1:0]      rd_slot_i,
  input  logic [KW-1:0]                     k_i,
  input  logic [pctk_pkg::CREG_W-1:0]       cols_i,
  output pctk_pkg::res_t                    res_o
);

  import pctk_pkg::*;

  logic [MASK_W-1:0]       upd;
  logic [CLW+RCOL_W-1:0]   col_ext;
  logic [CLW-1:0]          col_sel;
  logic                    in_range;

  for (genvar c = 0; c < MASK_W; c++) begin : g_upd
    if (c < MAX_COLUMNS) begin : g_lane
      assign upd[c] = take_i[c];
    end else begin : g_none
      assign upd[c] = 1'b0;
    end
  end

  assign col_ext  = {CLW'(0), rd_col_i};
  assign col_sel  = col_ext[CLW-1:0];
  assign in_range = (8'(rd_col_i) < 8'(cols_i)) && (8'(rd_col_i) < 8'(MAX_COLUMNS))
                    && (8'(rd_slot_i) < 8'(k_i));

  always_comb begin
    res_o              = '0;
    res_o.slot_sim     = SIM_EMPTY;
    case (req_i)
      REQ_ADD: begin
        res_o.accepted     = |upd;
        res_o.updated_mask = upd;
      end
      REQ_READ: begin
        if (in_range) begin
          res_o.slot_id  = lane_id_i[col_sel];
          res_o.slot_sim = lane_sim_i[col_sel];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### design/per_column_top_k_neighbor_tracker.sv
`timescale 1ns / 1ps
`include "per_column_top_k_neighbor_tracker_defines.svh"
// Per-column top-K neighbor tracker: one lane per column holds K (id, similarity) slots in a
// small RAM with one write and one read port plus valid bits, so a clear takes effect at once.
// Items are handled one at a time. Reads, clears and adds that no column takes pass through the
// issue, look and done states to the output register. An add that at least one column takes
// adds a rescan state: every updating lane rescans its K slots through its RAM read port, one
// slot per cycle, all lanes in lockstep. The result sits in an output register, so the next
// word is taken while it waits. The user must write configuration only while idle; the block
// itself does not enforce this. K = 0 acts as 1 and K above MAX_SLOTS as MAX_SLOTS.
module per_column_top_k_neighbor_tracker #(
  parameter int unsigned MAX_SLOTS   = pctk_pkg::DEF_MAX_SLOTS,
  parameter int unsigned MAX_COLUMNS = pctk_pkg::DEF_MAX_COLUMNS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // neighbor_id, similarity, present_mask, read_column, read_slot, zero fill
  input  logic [pctk_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic [pctk_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // accepted, updated_mask, slot_id, slot_similarity, zero fill
  output logic [pctk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [pctk_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pctk_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import pctk_pkg::*;

  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned KW = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_LOOK,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [REQ_W-1:0]        req_q;
  logic [ID_W-1:0]         id_q;
  logic signed [SIM_W-1:0] sim_q;
  logic [MASK_W-1:0]       mask_q;
  logic [RCOL_W-1:0]       rcol_q;
  logic [RSLOT_W-1:0]      rslot_q;
  logic [KREG_W-1:0]       k_reg_q;
  logic [CREG_W-1:0]       c_reg_q;
  logic [KW-1:0]           k_eff;
  logic [KW-1:0]           iss_q;
  logic                    scan_issue;
  logic                    dv_q;
  logic                    last_q;
  lane_ctl_t               ctl;
  logic [SW+RSLOT_W-1:0]   rslot_ext;
  logic [SW-1:0]           lane_addr;
  logic [MAX_COLUMNS-1:0]  col_en;
  logic [MAX_COLUMNS-1:0]  take;
  logic [ID_W-1:0]         lane_id [MAX_COLUMNS];
  logic signed [SIM_W-1:0] lane_sim [MAX_COLUMNS];
  res_t                    merged;
  res_t                    res_q;
  res_t                    out_q;
  logic                    out_vld_q;
  logic                    accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - RES_W){1'b0}}, out_q};

  always_comb begin
    if (k_reg_q == '0) begin
      k_eff = KW'(1);
    end else if (8'(k_reg_q) > 8'(MAX_SLOTS)) begin
      k_eff = KW'(MAX_SLOTS);
    end else begin
      k_eff = KW'(k_reg_q);
    end
  end

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_en
    if (c < MASK_W) begin : g_mask
      assign col_en[c] = mask_q[c] && (8'(c) < 8'(c_reg_q));
    end else begin : g_high
      assign col_en[c] = 1'b0;
    end
  end

  assign scan_issue = (state_q == ST_SCAN) && (iss_q < k_eff);
  assign rslot_ext  = {SW'(0), rslot_q};

  always_comb begin
    ctl         = '0;
    ctl.clear   = (state_q == ST_ISSUE) && (req_q == REQ_CLEAR);
    ctl.use_min = (state_q == ST_ISSUE) && (req_q == REQ_ADD);
    ctl.look    = (state_q == ST_LOOK) && (req_q == REQ_ADD);
    ctl.dv      = dv_q;
    ctl.last    = last_q;
    if (state_q == ST_SCAN) begin
      lane_addr = iss_q[SW-1:0];
    end else begin
      lane_addr = rslot_ext[SW-1:0];
    end
  end

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_lane
    pctk_lane #(
      .MAX_SLOTS(MAX_SLOTS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .en_i      (col_en[c]),
      .k_i       (k_eff),
      .addr_i    (lane_addr),
      .cand_id_i (id_q),
      .cand_sim_i(sim_q),
      .take_o    (take[c]),
      .rd_id_o   (lane_id[c]),
      .rd_sim_o  (lane_sim[c])
    );
  end

  pctk_merge #(
    .MAX_SLOTS  (MAX_SLOTS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_merge (
    .req_i     (req_q),
    .take_i    (take),
    .lane_id_i (lane_id),
    .lane_sim_i(lane_sim),
    .rd_col_i  (rcol_q),
    .rd_slot_i (rslot_q),
    .k_i       (k_eff),
    .cols_i    (c_reg_q),
    .res_o     (merged)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= s_axis_tuser;
      id_q    <= s_axis_tdata[ID_LSB +: ID_W];
      sim_q   <= s_axis_tdata[SIM_LSB +: SIM_W];
      mask_q  <= s_axis_tdata[MASK_LSB +: MASK_W];
      rcol_q  <= s_axis_tdata[RCOL_LSB +: RCOL_W];
      rslot_q <= s_axis_tdata[RSLOT_LSB +: RSLOT_W];
    end
    if (state_q == ST_LOOK) begin
      res_q <= merged;
    end
    if ((state_q == ST_DONE) && (!out_vld_q || m_axis_tready)) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      iss_q     <= '0;
      dv_q      <= 1'b0;
      last_q    <= 1'b0;
      k_reg_q   <= K_RESET;
      c_reg_q   <= C_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NEIGHBORS: k_reg_q <= cfg_data_i[KREG_W-1:0];
          REG_COLUMNS:   c_reg_q <= cfg_data_i[CREG_W-1:0];
          default: begin
          end
        endcase
      end
      if ((state_q == ST_DONE) && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      dv_q   <= scan_issue;
      last_q <= scan_issue && (iss_q == (k_eff - KW'(1)));
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          iss_q <= '0;
          if ((req_q == REQ_ADD) && (|take)) begin
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            iss_q <= iss_q + KW'(1);
          end
          if (dv_q && last_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold the result until the output register frees up
          if (!out_vld_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `PCTK_ASSERT(a_scan_needs_taker, (state_q == ST_SCAN) |-> res_q.accepted, "rescan, no taker")
  `PCTK_ASSERT(a_issue_bounded, (state_q == ST_SCAN) |-> (iss_q <= k_eff), "rescan past K")
  `PCTK_ASSERT(a_result_flags, out_vld_q |-> (out_q.accepted == (out_q.updated_mask != '0)), "flags")

endmodule
